### hw/rtl/single_source_shortest_path_defines.svh
// assertion helpers shared by the rtl
`ifndef SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATH_DEFINES_SVH

// checked only while out of reset
`define SSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define SSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/ssp_pkg.sv
`default_nettype none

package ssp_pkg;

  localparam int unsigned DIST_W           = 27;
  localparam int unsigned VC_W             = 5;
  localparam int unsigned OUT_LIMIT        = 16;
  localparam int unsigned MAX_VERTICES_DEF = 16;

  localparam logic [DIST_W-1:0] UNREACH = 27'd99999999;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_SOLVE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT_RD,
    S_INIT_WR,
    S_SCAN,
    S_RELAX_RD,
    S_RELAX_WR,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  edge_from;
    logic [3:0]  edge_to;
    logic [15:0] edge_weight;
  } in_word_t;

  typedef struct packed {
    logic [3:0]        vertex;
    logic [DIST_W-1:0] distance;
    logic              last;
  } out_word_t;

endpackage

`default_nettype wire

### hw/rtl/single_source_shortest_path.sv
// channel   direction  word        handshake
// in        input      in_word_t   in_valid_i / in_stall_o
// out       output     out_word_t  out_valid_o / out_stall_i
// cfg       input      5 bits      cfg_we_i, no wait
//
// add edge writes straight from idle; clear sweeps the whole edge memory, one entry a cycle
// (2**(2*clog2(MAX_VERTICES)) entries, 256 by default), and the same sweep runs after reset
// solve loads row 0 as the distances, then runs up to n-1 rounds of scan and relax, then sends
// n output words; the single edge memory read port and the shared compare set the pace
// in_stall_o is high whenever the sequencer is not idle; out_stall_i holds the output word

`default_nettype none

`include "single_source_shortest_path_defines.svh"

module single_source_shortest_path #(
  parameter int unsigned MAX_VERTICES = ssp_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire ssp_pkg::in_word_t                in_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output ssp_pkg::out_word_t                    out_word_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [ssp_pkg::VC_W-1:0]         cfg_wdata_i
);

  localparam int unsigned VW     = $clog2(MAX_VERTICES);
  localparam int unsigned ADDR_W = 2 * VW;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam int unsigned LIMIT  = (MAX_VERTICES < ssp_pkg::OUT_LIMIT) ?
                                   MAX_VERTICES : ssp_pkg::OUT_LIMIT;
  localparam int unsigned DW     = ssp_pkg::DIST_W;
  localparam int unsigned NV     = ssp_pkg::OUT_LIMIT;

  ssp_pkg::state_e state_q, state_d;

  logic [ADDR_W-1:0]       cnt_q, cnt_d;
  logic [3:0]              j_q, j_d;
  logic [3:0]              u_q, u_d;
  logic [DW-1:0]           least_q, least_d;
  logic                    found_q, found_d;
  logic [ssp_pkg::VC_W-1:0] round_q, round_d;
  logic [ssp_pkg::VC_W-1:0] vc_q, vc_d;
  logic [DW-1:0]           best_q [NV];
  logic [DW-1:0]           best_d [NV];
  logic                    settled_q [NV];
  logic                    settled_d [NV];

  logic                    we;
  logic [ADDR_W-1:0]       waddr;
  logic [DW-1:0]           wdata;
  logic [ADDR_W-1:0]       raddr;
  logic [DW-1:0]           rdata;

  logic [ssp_pkg::VC_W-1:0] n_act;
  logic                    last_j;
  logic [7:0]              from8, to8, j8, u8;
  logic                    edge_ok;
  logic [DW:0]             sum;
  logic [DW-1:0]           sum_sat;
  logic [DW-1:0]           cmp_a, cmp_b;
  logic                    cmp_lt;
  logic                    take;
  logic [3:0]              u_new;

  assign from8 = {4'b0, in_word_i.edge_from};
  assign to8   = {4'b0, in_word_i.edge_to};
  assign j8    = {4'b0, j_q};
  assign u8    = {4'b0, u_q};
  assign edge_ok = (32'(in_word_i.edge_from) < MAX_VERTICES) &&
                   (32'(in_word_i.edge_to) < MAX_VERTICES);

  always_comb begin
    if (vc_q == '0) begin
      n_act = ssp_pkg::VC_W'(1);
    end else if (vc_q > ssp_pkg::VC_W'(LIMIT)) begin
      n_act = ssp_pkg::VC_W'(LIMIT);
    end else begin
      n_act = vc_q;
    end
  end

  assign last_j = ({1'b0, j_q} == (n_act - ssp_pkg::VC_W'(1)));

  // row 0 during init, settled vertex during relax
  assign raddr = {((state_q == ssp_pkg::S_INIT_RD) ? VW'(0) : u8[VW-1:0]), j8[VW-1:0]};

  assign sum     = {1'b0, least_q} + {1'b0, rdata};
  assign sum_sat = (sum > {1'b0, ssp_pkg::UNREACH}) ? ssp_pkg::UNREACH : sum[DW-1:0];

  // shared compare: scan looks for a smaller distance, relax for a shorter path
  assign cmp_a  = (state_q == ssp_pkg::S_RELAX_WR) ? sum_sat : best_q[j_q];
  assign cmp_b  = (state_q == ssp_pkg::S_RELAX_WR) ? best_q[j_q] : least_q;
  assign cmp_lt = cmp_a < cmp_b;

  assign take  = !settled_q[j_q] && cmp_lt;
  assign u_new = take ? j_q : u_q;

  ssp_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssp_pkg::S_CLEAR;
      cnt_q   <= '0;
      j_q     <= '0;
      round_q <= '0;
      vc_q    <= ssp_pkg::VC_W'(16);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      j_q     <= j_d;
      round_q <= round_d;
      vc_q    <= vc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q       <= u_d;
    least_q   <= least_d;
    found_q   <= found_d;
    best_q    <= best_d;
    settled_q <= settled_d;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    j_d       = j_q;
    u_d       = u_q;
    least_d   = least_q;
    found_d   = found_q;
    round_d   = round_q;
    vc_d      = cfg_we_i ? cfg_wdata_i : vc_q;
    best_d    = best_q;
    settled_d = settled_q;
    we        = 1'b0;
    waddr     = {from8[VW-1:0], to8[VW-1:0]};
    wdata     = DW'(in_word_i.edge_weight);
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;

    unique case (state_q)
      ssp_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = (cnt_q[ADDR_W-1:VW] == cnt_q[VW-1:0]) ? '0 : ssp_pkg::UNREACH;
        cnt_d = cnt_q + ADDR_W'(1);
        if (&cnt_q) begin
          state_d = ssp_pkg::S_IDLE;
        end
      end
      ssp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (in_word_i.action)
            ssp_pkg::ACT_CLEAR: begin
              cnt_d   = '0;
              state_d = ssp_pkg::S_CLEAR;
            end
            ssp_pkg::ACT_ADD: begin
              we = edge_ok;
            end
            ssp_pkg::ACT_SOLVE: begin
              j_d     = '0;
              state_d = ssp_pkg::S_INIT_RD;
            end
            default: ;
          endcase
        end
      end
      ssp_pkg::S_INIT_RD: begin
        state_d = ssp_pkg::S_INIT_WR;
      end
      ssp_pkg::S_INIT_WR: begin
        best_d[j_q]    = (j_q == '0) ? '0 : rdata;
        settled_d[j_q] = (j_q == '0);
        if (last_j) begin
          round_d = ssp_pkg::VC_W'(1);
          j_d     = '0;
          least_d = ssp_pkg::UNREACH;
          found_d = 1'b0;
          u_d     = '0;
          state_d = (n_act == ssp_pkg::VC_W'(1)) ? ssp_pkg::S_EMIT : ssp_pkg::S_SCAN;
        end else begin
          j_d     = j_q + 4'd1;
          state_d = ssp_pkg::S_INIT_RD;
        end
      end
      ssp_pkg::S_SCAN: begin
        if (take) begin
          least_d = best_q[j_q];
          u_d     = j_q;
          found_d = 1'b1;
        end
        if (last_j) begin
          j_d = '0;
          if (found_q || take) begin
            settled_d[u_new] = 1'b1;
            state_d          = ssp_pkg::S_RELAX_RD;
          end else begin
            state_d = ssp_pkg::S_EMIT;
          end
        end else begin
          j_d = j_q + 4'd1;
        end
      end
      ssp_pkg::S_RELAX_RD: begin
        state_d = ssp_pkg::S_RELAX_WR;
      end
      ssp_pkg::S_RELAX_WR: begin
        if ((rdata < ssp_pkg::UNREACH) && cmp_lt) begin
          best_d[j_q] = sum_sat;
        end
        if (last_j) begin
          round_d = round_q + ssp_pkg::VC_W'(1);
          j_d     = '0;
          least_d = ssp_pkg::UNREACH;
          found_d = 1'b0;
          u_d     = '0;
          state_d = (round_d == n_act) ? ssp_pkg::S_EMIT : ssp_pkg::S_SCAN;
        end else begin
          j_d     = j_q + 4'd1;
          state_d = ssp_pkg::S_RELAX_RD;
        end
      end
      ssp_pkg::S_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (last_j) begin
            state_d = ssp_pkg::S_IDLE;
          end else begin
            j_d = j_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = ssp_pkg::S_IDLE;
      end
    endcase
  end

  assign out_word_o.vertex   = j_q;
  assign out_word_o.distance = best_q[j_q];
  assign out_word_o.last     = last_j;

  `SSP_ASSERT_ALWAYS(a_no_accept_while_emitting, out_valid_o |-> in_stall_o,
    "input taken while distances are being sent")
  `SSP_ASSERT(a_idle_after_last,
    (out_valid_o && !out_stall_i && out_word_o.last) |=> !in_stall_o,
    "block not ready after the last distance word")
  `SSP_ASSERT(a_source_zero, (out_valid_o && (out_word_o.vertex == 4'd0)) |->
    (out_word_o.distance == '0), "source vertex reported with a non-zero distance")
  `SSP_ASSERT(a_settle_on_relax,
    (state_q == ssp_pkg::S_SCAN && state_d == ssp_pkg::S_RELAX_RD) |=> settled_q[u_q],
    "vertex relaxed without being settled")

endmodule

`default_nettype wire

### hw/rtl/ssp_ram.sv
`default_nettype none

module ssp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire
